// ===== rtl/core/srmv_pkg.sv =====
// Shared types, codes and constants for the sparse row matvec block.
package srmv_pkg;

  localparam int IDX_W           = 12;
  localparam int DATA_W          = 32;
  localparam int ACC_W           = 48;
  localparam int PROD_W          = 2 * DATA_W;
  localparam int FRAC_W          = 16;
  localparam int DEF_MODEL_DEPTH = 4096;

  // Front-to-back queue; a power of two so the pointers wrap on their own.
  localparam int Q_DEPTH = 4;
  localparam int QA_W    = $clog2(Q_DEPTH);
  localparam int QC_W    = QA_W + 1;

  // Configuration port: word-aligned registers, bit 2 selects the word.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [0:0] REG_CORRECT_MODE = 1'b0;

  localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0]  A_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0]  A_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_ADD   = 2'd1,
    FUNC_MAC   = 2'd2,
    FUNC_CLOSE = 2'd3
  } func_t;

  typedef struct packed {
    func_t                     func;
    logic [IDX_W-1:0]          index;
    logic signed [DATA_W-1:0]  value;
    logic signed [DATA_W-1:0]  data_in;
    logic                      row_end;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  row_result;
    logic                      saturated;
  } out_item_t;

  // Classified item as queued between front and back.
  typedef struct packed {
    func_t                     func;
    logic [IDX_W-1:0]          index;
    logic                      in_range;
    logic signed [DATA_W-1:0]  value;
    logic signed [DATA_W-1:0]  data_in;
    logic                      row_end;
  } q_item_t;

endpackage

// ===== rtl/core/sparse_row_matvec_correct.sv =====
// Top level of the sparse row matvec block: config register, front end and back end.
//
// Usage
//   in_*  : one beat per item. func selects write model element, add to model
//           element, matrix entry, or close empty row. Model items load the
//           4096-entry model store; matrix entries of one row follow in order,
//           the last flagged by row_end.
//   out_* : one beat per finished row: the row sum (replace mode) or data_in
//           minus the row sum (correct mode), saturated to Q16.16 with a flag.
//   cfg_* : APB-style; word 0 bit 0 is correct_mode. Change it only when idle.
// Throughput: one input beat per cycle while out_stall is low; the model
//   store has one write and one read port, and a write followed by a read
//   of the same element in the next beat is bypassed, so no hazard stalls.
// Path: the beat that closes a row passes the queue, model read, multiply,
//   accumulate and result registers before its result beat is offered.
// Stall: a stalled result holds the whole back end; the four-deep queue fills
//   and in_stall rises once it is full.
// Reset: clears valids, the row accumulator and correct_mode. The model store
//   is not cleared; elements read before being written return garbage.
module sparse_row_matvec_correct import srmv_pkg::*; #(
  parameter int MODEL_DEPTH = DEF_MODEL_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  // configuration port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic    mode_r, mode_nxt;
  logic    cfg_wr;
  logic    cfg_sel_mode;
  logic    q_valid;
  logic    q_pop;
  q_item_t q_item;

  // ---- configuration ----
  assign cfg_pready   = 1'b1;
  assign cfg_wr       = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel_mode = (cfg_paddr[CFG_AW-1:2] == REG_CORRECT_MODE);

  always_comb begin
    mode_nxt = mode_r;
    if (cfg_wr && cfg_sel_mode) begin
      mode_nxt = cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  assign cfg_prdata = cfg_sel_mode ? {{(CFG_DW-1){1'b0}}, mode_r} : '0;

  // ---- front end: accept, classify, queue ----
  srmv_front #(
    .MODEL_DEPTH (MODEL_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // ---- back end: model store and MAC pipeline ----
  srmv_back #(
    .MODEL_DEPTH (MODEL_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .correct_mode (mode_r),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

  // ---- assertions ----
  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.saturated) |->
      (out_data.row_result == Q_MAX || out_data.row_result == Q_MIN))
    else $error("saturated flag without a clipped result");

  a_mode_reset: assert property (@(posedge clk)
    !rst_n |=> !mode_r)
    else $error("correct_mode not cleared by reset");

endmodule

// ===== rtl/core/srmv_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module srmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read-first: a read and a write to one address in one cycle returns old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/srmv_front.sv =====
// Front end: accepts input beats, classifies them and queues them for the back end.
module srmv_front import srmv_pkg::*; #(
  parameter int MODEL_DEPTH = DEF_MODEL_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     q_valid,
  output q_item_t  q_item,
  input  logic     q_pop
);

  q_item_t         q_mem_r [Q_DEPTH];
  logic [QA_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QA_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0] cnt_r, cnt_nxt;
  logic            push;
  q_item_t         cls_item;

  assign in_stall = (cnt_r == QC_W'(Q_DEPTH));
  assign push     = in_valid && !in_stall;

  always_comb begin
    cls_item.func     = in_data.func;
    cls_item.index    = in_data.index;
    cls_item.in_range = (32'(in_data.index) < 32'(MODEL_DEPTH));
    cls_item.value    = in_data.value;
    cls_item.data_in  = in_data.data_in;
    cls_item.row_end  = in_data.row_end;
  end

  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QC_W'(push) - QC_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls_item;
    end
  end

  assign q_valid = (cnt_r != '0);
  assign q_item  = q_mem_r[rd_ptr_r];

endmodule

// ===== rtl/core/srmv_back.sv =====
// Back end: model store, multiply-accumulate pipeline and result register.
module srmv_back import srmv_pkg::*; #(
  parameter int MODEL_DEPTH = DEF_MODEL_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  q_item_t   q_item,
  output logic      q_pop,
  input  logic      correct_mode,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int AW = (MODEL_DEPTH > 1) ? $clog2(MODEL_DEPTH) : 1;

  logic adv;

  // stage 1: model read data arrives
  logic                     s1_valid_r;
  q_item_t                  s1_item_r;
  logic                     s1_fwd_r;
  logic signed [DATA_W-1:0] s1_fwd_data_r;
  logic [DATA_W-1:0]        ram_rdata;
  logic signed [DATA_W-1:0] model_val;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [DATA_W:0]   add_sum;
  logic signed [DATA_W-1:0] add_sat;
  logic signed [PROD_W-1:0] prod;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic signed [DATA_W-1:0] wr_data;

  // stage 2: accumulate
  logic                     s2_valid_r;
  logic                     s2_close_r;
  logic                     s2_row_end_r;
  logic signed [PROD_W-1:0] s2_prod_r;
  logic signed [DATA_W-1:0] s2_data_in_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W-1:0]  prod_q;
  logic signed [ACC_W:0]    acc_sum;
  logic signed [ACC_W-1:0]  acc_sat;

  // stage 3: row sum ready for the output stage
  logic                     s3_valid_r;
  logic                     s3_close_r;
  logic signed [ACC_W-1:0]  s3_sum_r;
  logic signed [DATA_W-1:0] s3_data_in_r;
  logic signed [ACC_W:0]    diff;
  out_item_t                res;

  logic                     out_valid_r;
  out_item_t                out_data_r;

  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && q_valid;

  srmv_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MODEL_DEPTH)
  ) u_model_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (adv),
    .raddr (AW'(q_item.index)),
    .rdata (ram_rdata)
  );

  // ---- stage 1 ----
  always_comb begin
    model_val = s1_fwd_r ? s1_fwd_data_r : $signed(ram_rdata);
    add_sum   = {model_val[DATA_W-1], model_val} +
                {s1_item_r.value[DATA_W-1], s1_item_r.value};
    if (add_sum[DATA_W] != add_sum[DATA_W-1]) begin
      add_sat = add_sum[DATA_W] ? Q_MIN : Q_MAX;
    end else begin
      add_sat = add_sum[DATA_W-1:0];
    end
    wr_en   = adv && s1_valid_r && s1_item_r.in_range &&
              (s1_item_r.func == FUNC_WRITE || s1_item_r.func == FUNC_ADD);
    wr_addr = AW'(s1_item_r.index);
    wr_data = (s1_item_r.func == FUNC_WRITE) ? s1_item_r.value : add_sat;
    mul_b   = s1_item_r.in_range ? model_val : '0;
    prod    = $signed(s1_item_r.value) * $signed(mul_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= q_valid;
    end
  end

  // bypass a write that lands on the address being read in the same cycle
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r     <= q_item;
      s1_fwd_r      <= wr_en && (wr_addr == AW'(q_item.index));
      s1_fwd_data_r <= wr_data;
    end
  end

  // ---- stage 2 ----
  always_comb begin
    prod_q  = s2_prod_r[PROD_W-1:FRAC_W];  // floor shift, fits in 48 bits
    acc_sum = {acc_r[ACC_W-1], acc_r} + {prod_q[ACC_W-1], prod_q};
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_sat = acc_sum[ACC_W] ? A_MIN : A_MAX;
    end else begin
      acc_sat = acc_sum[ACC_W-1:0];
    end
    acc_nxt = acc_r;
    if (adv && s2_valid_r) begin
      acc_nxt = (s2_close_r || s2_row_end_r) ? '0 : acc_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      acc_r      <= '0;
    end else begin
      acc_r <= acc_nxt;
      if (adv) begin
        s2_valid_r <= s1_valid_r &&
                      (s1_item_r.func == FUNC_MAC || s1_item_r.func == FUNC_CLOSE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_close_r   <= (s1_item_r.func == FUNC_CLOSE);
      s2_row_end_r <= s1_item_r.row_end;
      s2_prod_r    <= prod;
      s2_data_in_r <= s1_item_r.data_in;
    end
  end

  // ---- stage 3 ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r && (s2_close_r || s2_row_end_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_close_r   <= s2_close_r;
      s3_sum_r     <= acc_sat;
      s3_data_in_r <= s2_data_in_r;
    end
  end

  // ---- result stage ----
  always_comb begin
    if (correct_mode) begin
      diff = {{(ACC_W-DATA_W+1){s3_data_in_r[DATA_W-1]}}, s3_data_in_r} -
             {s3_sum_r[ACC_W-1], s3_sum_r};
    end else begin
      diff = {s3_sum_r[ACC_W-1], s3_sum_r};
    end
    if (s3_close_r) begin
      res.row_result = correct_mode ? s3_data_in_r : '0;
      res.saturated  = 1'b0;
    end else if (diff[ACC_W:DATA_W-1] != {(ACC_W-DATA_W+2){diff[ACC_W]}}) begin
      res.row_result = diff[ACC_W] ? Q_MIN : Q_MAX;
      res.saturated  = 1'b1;
    end else begin
      res.row_result = diff[DATA_W-1:0];
      res.saturated  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
